### rtl/cac_pkg.sv
// package with types, codes and constants for the call arc counter
`timescale 1ns / 1ps
`default_nettype none
package cac_pkg;

    localparam int BucketEntriesDefault = 4096;
    localparam int ArcEntriesDefault    = 4096;

    localparam logic [2:0] ST_COUNTED  = 3'd0;
    localparam logic [2:0] ST_NEW      = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_OFF      = 3'd4;

    localparam logic [2:0] REG_ENABLE   = 3'd0;
    localparam logic [2:0] REG_LOW_PC   = 3'd1;
    localparam logic [2:0] REG_TEXT     = 3'd2;
    localparam logic [2:0] REG_SHIFT    = 3'd3;
    localparam logic [2:0] REG_LIMIT    = 3'd4;

    typedef struct packed {
        logic [31:0] caller_addr;
        logic [31:0] callee_addr;
    } cac_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] arc_count;
        logic [11:0] arc_slot;
    } cac_out_t;

endpackage
`default_nettype wire

### rtl/cac_ram.sv
// generic single-port-write, single-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### rtl/call_arc_counter_unit.sv
// top level of the call arc counter: hashed buckets with chained arcs in ram
// One transaction at a time. Out-of-range, disabled and overflowed requests go
// straight to the output state; a hit at the chain head reads the head, reads the
// arc, compares and writes back, then outputs, after which the result is valid;
// an empty bucket skips the arc read and allocates; each further link walked
// adds a read of the arc memory; a move-to-front hit adds the relink writes.
// After reset the bucket head memory is cleared one entry a cycle, during which
// no request is taken; configuration writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module call_arc_counter_unit
    import cac_pkg::*;
#(
    parameter int BUCKET_ENTRIES = BucketEntriesDefault,
    parameter int ARC_ENTRIES    = ArcEntriesDefault
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire cac_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output cac_out_t      m_data,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int BW = $clog2(BUCKET_ENTRIES);
    localparam int AW = $clog2(ARC_ENTRIES);
    localparam int NW = AW + 1;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_HEAD   = 9'b000000100,
        S_ARC    = 9'b000001000,
        S_CHECK  = 9'b000010000,
        S_WALK   = 9'b000100000,
        S_MOVE1  = 9'b001000000,
        S_MOVE2  = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic        enable_reg;
    logic [31:0] low_pc_reg, text_reg;
    logic [4:0]  shift_reg;
    logic [12:0] limit_reg;
    logic [NW-1:0] free_reg;
    logic        ovf_reg;
    logic [BW-1:0] clr_reg;

    logic [BW-1:0] bucket_reg;
    logic [31:0]   callee_reg;
    logic [AW-1:0] head_reg, prev_reg, cur_reg;
    logic [AW:0]   steps_reg;
    cac_out_t      out_reg;

    // memories
    logic          hd_we;
    logic [BW-1:0] hd_waddr, hd_raddr;
    logic [AW-1:0] hd_wdata, hd_rdata;
    logic          ac_we, cn_we, lk_we;
    logic [AW-1:0] ac_waddr, cn_waddr, lk_waddr, a_raddr;
    logic [31:0]   ac_wdata, cn_wdata, ac_rdata, cn_rdata;
    logic [AW-1:0] lk_wdata, lk_rdata;

    cac_ram #(.WIDTH(AW), .DEPTH(BUCKET_ENTRIES)) u_heads (
        .aclk, .we(hd_we), .waddr(hd_waddr), .wdata(hd_wdata),
        .raddr(hd_raddr), .rdata(hd_rdata));
    cac_ram #(.WIDTH(32), .DEPTH(ARC_ENTRIES)) u_callee (
        .aclk, .we(ac_we), .waddr(ac_waddr), .wdata(ac_wdata),
        .raddr(a_raddr), .rdata(ac_rdata));
    cac_ram #(.WIDTH(32), .DEPTH(ARC_ENTRIES)) u_counts (
        .aclk, .we(cn_we), .waddr(cn_waddr), .wdata(cn_wdata),
        .raddr(a_raddr), .rdata(cn_rdata));
    cac_ram #(.WIDTH(AW), .DEPTH(ARC_ENTRIES)) u_links (
        .aclk, .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(a_raddr), .rdata(lk_rdata));

    // front-end decode of the incoming transaction
    logic [31:0] caller_off, callee_off, bucket_full;
    logic        in_range;
    assign caller_off  = s_data.caller_addr - low_pc_reg;
    assign callee_off  = s_data.callee_addr - low_pc_reg;
    assign bucket_full = caller_off >> shift_reg;
    assign in_range    = (caller_off <= text_reg) &&
                         (bucket_full < 32'(BUCKET_ENTRIES));

    // allocation limit saturated at the arc store depth
    logic [NW:0] lim, cand;
    assign lim  = (32'(limit_reg) > 32'(ARC_ENTRIES)) ? (NW+1)'(ARC_ENTRIES)
                                                       : (NW+1)'(limit_reg);
    assign cand = (NW+1)'(free_reg) + 1'b1;

    logic accept;
    assign s_ready = (state_reg == S_IDLE) && !m_valid;
    assign accept  = s_valid && s_ready;

    // decision in the check state
    logic hit;
    assign hit = (ac_rdata == callee_reg);

    logic [31:0] cnt_inc;
    assign cnt_inc = cn_rdata + 32'd1;

    always_comb begin
        state_next = state_reg;
        hd_we = 1'b0; hd_waddr = bucket_reg; hd_wdata = '0;
        hd_raddr = bucket_full[BW-1:0];
        ac_we = 1'b0; ac_waddr = '0; ac_wdata = callee_reg;
        cn_we = 1'b0; cn_waddr = '0; cn_wdata = 32'd1;
        lk_we = 1'b0; lk_waddr = '0; lk_wdata = '0;
        a_raddr = cur_reg;
        case (state_reg)
            S_CLEAR: begin
                hd_we = 1'b1; hd_waddr = clr_reg; hd_wdata = '0;
                if (clr_reg == BW'(BUCKET_ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (!enable_reg || ovf_reg || !in_range) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                // head read data now valid
                a_raddr = hd_rdata;
                if (hd_rdata == '0) begin
                    state_next = S_CHECK;
                end else begin
                    state_next = S_ARC;
                end
            end
            S_ARC: begin
                state_next = S_CHECK;
            end
            S_CHECK: begin
                if (cur_reg != '0 && hit && steps_reg <= (AW+1)'(ARC_ENTRIES)) begin
                    cn_we = 1'b1; cn_waddr = cur_reg; cn_wdata = cnt_inc;
                    if (cur_reg == head_reg) begin
                        state_next = S_OUT;
                    end else begin
                        // unlink cur from behind prev
                        lk_we = 1'b1; lk_waddr = prev_reg; lk_wdata = lk_rdata;
                        state_next = S_MOVE1;
                    end
                end else if (cur_reg != '0 && lk_rdata != '0 &&
                             steps_reg < (AW+1)'(ARC_ENTRIES)) begin
                    a_raddr = lk_rdata;
                    state_next = S_WALK;
                end else begin
                    // miss: allocate while below the limit
                    if (cand < lim) begin
                        ac_we = 1'b1; ac_waddr = cand[AW-1:0];
                        cn_we = 1'b1; cn_waddr = cand[AW-1:0]; cn_wdata = 32'd1;
                        lk_we = 1'b1; lk_waddr = cand[AW-1:0]; lk_wdata = head_reg;
                        hd_we = 1'b1; hd_wdata = cand[AW-1:0];
                    end
                    state_next = S_OUT;
                end
            end
            S_WALK: begin
                state_next = S_CHECK;
            end
            S_MOVE1: begin
                lk_we = 1'b1; lk_waddr = cur_reg; lk_wdata = head_reg;
                hd_we = 1'b1; hd_wdata = cur_reg;
                state_next = S_MOVE2;
            end
            S_MOVE2: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            clr_reg    <= '0;
            enable_reg <= 1'b0;
            low_pc_reg <= '0;
            text_reg   <= '0;
            shift_reg  <= 5'd1;
            limit_reg  <= 13'd4096;
            free_reg   <= '0;
            ovf_reg    <= 1'b0;
            m_valid    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_LOW_PC: low_pc_reg <= cfg_data;
                    REG_TEXT:   text_reg   <= cfg_data;
                    REG_SHIFT:  shift_reg  <= cfg_data[4:0];
                    REG_LIMIT:  limit_reg  <= cfg_data[12:0];
                    default: ;
                endcase
            end
            if (state_reg == S_CHECK && state_next == S_OUT && !(cur_reg != '0 && hit
                && steps_reg <= (AW+1)'(ARC_ENTRIES))) begin
                if (cand < lim) begin
                    free_reg <= cand[NW-1:0];
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (state_reg == S_OUT) begin
                m_valid <= 1'b1;
            end else if (m_valid && m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                bucket_reg <= bucket_full[BW-1:0];
                callee_reg <= callee_off;
                steps_reg  <= '0;
                if (accept) begin
                    out_reg.arc_count <= '0;
                    out_reg.arc_slot  <= '0;
                    out_reg.status    <= (!enable_reg || ovf_reg) ? ST_OFF : ST_RANGE;
                end
            end
            S_HEAD: begin
                head_reg <= hd_rdata;
                cur_reg  <= hd_rdata;
                prev_reg <= hd_rdata;
            end
            S_CHECK: begin
                if (cur_reg != '0 && hit && steps_reg <= (AW+1)'(ARC_ENTRIES)) begin
                    out_reg.status    <= ST_COUNTED;
                    out_reg.arc_count <= cnt_inc;
                    out_reg.arc_slot  <= 12'(cur_reg);
                end else if (cur_reg != '0 && lk_rdata != '0 &&
                             steps_reg < (AW+1)'(ARC_ENTRIES)) begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= lk_rdata;
                    steps_reg <= steps_reg + 1'b1;
                end else if (cand < lim) begin
                    out_reg.status    <= ST_NEW;
                    out_reg.arc_count <= 32'd1;
                    out_reg.arc_slot  <= 12'(cand[AW-1:0]);
                end else begin
                    out_reg.status    <= ST_OVERFLOW;
                    out_reg.arc_count <= '0;
                    out_reg.arc_slot  <= '0;
                end
            end
            default: ;
        endcase
    end

    assign m_data = out_reg;
endmodule
`default_nettype wire

### rtl/cac_checker.sv
// port-level checker for the call arc counter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module cac_checker
    import cac_pkg::*;
(
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire cac_out_t m_data
);
    a_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_RANGE || m_data.status == ST_OFF ||
        m_data.status == ST_OVERFLOW) |-> m_data.arc_count == '0 && m_data.arc_slot == '0)
        else $error("uncounted result carries data");
    a_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_NEW |-> m_data.arc_count == 32'd1 &&
        m_data.arc_slot != '0)
        else $error("bad new arc result");
endmodule

bind call_arc_counter_unit cac_checker u_cac_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_data);
`default_nettype wire
